>>> rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_W     = 16;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = 4;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = PROD_W + IDX_W;
  localparam int SUM_W      = 32;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_INNER_K = 2'd1;
  localparam logic [1:0] REG_COLS_N  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             rd_en;
    logic             rd_first;
    logic             rd_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] t;
    logic             emit;
    logic             emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } status_t;

  // Zero reads as one, anything above the maximum reads as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    d = r;
    if (r == '0) d = DIM_W'(1);
    else if (r > DIM_W'(MAX_DIM)) d = DIM_W'(MAX_DIM);
    return d;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [SUM_W-1:0] s;
    hi = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
    lo = {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
    if (a > hi) s = {1'b0, {(SUM_W-1){1'b1}}};
    else if (a < lo) s = {1'b1, {(SUM_W-1){1'b0}}};
    else s = a[SUM_W-1:0];
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mme_ctrl.sv
// Sequencer for the matrix multiply engine: walks rows, columns and the inner index.
// Depends on mme_pkg; drives mme_dp through cmd_t and reads status_t.
`default_nettype none

module mme_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            kind,
  input  wire logic [mme_pkg::DIM_W-1:0] dim_m,
  input  wire logic [mme_pkg::DIM_W-1:0] dim_k,
  input  wire logic [mme_pkg::DIM_W-1:0] dim_n,
  input  wire mme_pkg::status_t      status,
  output logic                       in_ready,
  output mme_pkg::cmd_t              cmd
);
  import mme_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] t;
  logic             t_last;
  logic             j_last;
  logic             i_last;
  logic             accept;
  logic             emit;

  assign t_last = ({1'b0, t} == dim_k - DIM_W'(1));
  assign j_last = ({1'b0, j} == dim_n - DIM_W'(1));
  assign i_last = ({1'b0, i} == dim_m - DIM_W'(1));
  assign accept = in_valid && (state == ST_IDLE);
  assign emit   = (state == ST_WAIT) && status.acc_done && status.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_COMPUTE) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (t_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (emit) state_next = (i_last && j_last) ? ST_IDLE : ST_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.t         = t;
    cmd.rd_first  = (t == '0);
    cmd.rd_last   = t_last;
    cmd.emit_last = i_last && j_last;
    case (state)
      ST_IDLE: begin
        cmd.load_a = accept && (kind == KIND_LOAD_A);
        cmd.load_b = accept && (kind == KIND_LOAD_B);
      end
      ST_ISSUE: cmd.rd_en = 1'b1;
      ST_WAIT:  cmd.emit  = emit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      t     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          i <= '0;
          j <= '0;
          t <= '0;
        end
        ST_ISSUE: begin
          t <= t_last ? '0 : t + IDX_W'(1);
        end
        ST_WAIT: begin
          // advance to the next element in row-major order
          if (emit) begin
            if (j_last) begin
              j <= '0;
              i <= i + IDX_W'(1);
            end else begin
              j <= j + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mme_dp.sv
// Datapath: A and B element memories, multiply-accumulate pipeline, output register.
// Depends on mme_pkg; commanded by mme_ctrl.
`default_nettype none

module mme_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mme_pkg::cmd_t               cmd,
  input  wire logic [mme_pkg::IDX_W-1:0]   row,
  input  wire logic [mme_pkg::IDX_W-1:0]   col,
  input  wire logic signed [mme_pkg::ELEM_W-1:0] value,
  input  wire logic                        out_ready,
  output mme_pkg::status_t                 status,
  output logic                             out_valid,
  output logic [mme_pkg::IDX_W-1:0]        out_row,
  output logic [mme_pkg::IDX_W-1:0]        out_col,
  output logic signed [mme_pkg::SUM_W-1:0] sum,
  output logic                             last
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];

  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic                     rd_v;
  logic                     rd_first;
  logic                     rd_last;
  logic signed [PROD_W-1:0] prod;
  logic                     p_v;
  logic                     p_first;
  logic                     p_last;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     acc_done;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_a) a_mem[{row, col}] <= value;
    if (cmd.load_b) b_mem[{row, col}] <= value;
    if (cmd.rd_en) begin
      a_q <= a_mem[{cmd.i, cmd.t}];
      b_q <= b_mem[{cmd.t, cmd.j}];
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= cmd.rd_first;
    rd_last  <= cmd.rd_last;
    prod     <= a_q * b_q;
    p_first  <= rd_first;
    p_last   <= rd_last;
  end

  assign prod_ext = ACC_W'(prod);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      p_v      <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
      p_v  <= rd_v;
      if (p_v && p_last) acc_done <= 1'b1;
      else if (cmd.emit) acc_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_v) acc <= p_first ? prod_ext : acc + prod_ext;
  end

  // Output register: hold while stalled, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row <= cmd.i;
      out_col <= cmd.j;
      sum     <= sat_sum(acc);
      last    <= cmd.emit_last;
    end
  end

  assign status.acc_done = acc_done;
  assign status.out_free = out_free;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: configuration registers and APB port,
// controller and datapath. Depends on mme_pkg, mme_ctrl and mme_dp.
//
// Usage:
//   Set rows_m, inner_k and cols_n over the APB port (byte addresses 0, 4, 8)
//   while the engine is idle. A value of 0 acts as 1, above 8 acts as 8.
//   Input items (in_valid/in_ready) carry kind, row, col and value. Kind 0
//   writes an element of A, kind 1 an element of B; a load leaves in_ready high.
//   Kind 2 runs C = A * B and returns M*N result items (out_valid/out_ready)
//   in row-major order, last set on the final one. Kind 3 is dropped.
//   For each result, K reads pass through the single read port of each
//   element memory, then the multiply and accumulate stages; a compute item
//   holds the input channel until its last result has been emitted.
//   One input item is in work at a time; in_ready is low during a compute.
//   A result waits in the output register while out_ready is low; the next
//   element is computed meanwhile and held until that register frees up.
//   Reset sets all three dimensions to 8 and clears the control state; the
//   element memories keep their contents and must be written before use.
`default_nettype none

module matrix_multiply_engine_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mme_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [mme_pkg::PDATA_W-1:0]       pwdata,
  output logic [mme_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        kind,
  input  wire logic [mme_pkg::IDX_W-1:0]         row,
  input  wire logic [mme_pkg::IDX_W-1:0]         col,
  input  wire logic signed [mme_pkg::ELEM_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mme_pkg::IDX_W-1:0]              out_row,
  output logic [mme_pkg::IDX_W-1:0]              out_col,
  output logic signed [mme_pkg::SUM_W-1:0]       sum,
  output logic                                   last
);
  import mme_pkg::*;

  logic [DIM_W-1:0] rows_m;
  logic [DIM_W-1:0] inner_k;
  logic [DIM_W-1:0] cols_n;
  logic [1:0]       reg_idx;
  logic             reg_wr;
  cmd_t             cmd;
  status_t          status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= DIM_RESET;
      inner_k <= DIM_RESET;
      cols_n  <= DIM_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_ROWS_M:  rows_m  <= pwdata[DIM_W-1:0];
        REG_INNER_K: inner_k <= pwdata[DIM_W-1:0];
        REG_COLS_N:  cols_n  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_M:  prdata = PDATA_W'(rows_m);
      REG_INNER_K: prdata = PDATA_W'(inner_k);
      REG_COLS_N:  prdata = PDATA_W'(cols_n);
      default:     prdata = '0;
    endcase
  end

  mme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .dim_m    (eff_dim(rows_m)),
    .dim_k    (eff_dim(inner_k)),
    .dim_n    (eff_dim(cols_n)),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mme_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum       (sum),
    .last      (last)
  );

endmodule

`default_nettype wire

>>> rtl/mme_checker.sv
// Port-level checks for matrix_multiply_engine_core, attached by bind.
// Depends on mme_pkg.
`default_nettype none

module mme_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [1:0]                        kind,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [mme_pkg::IDX_W-1:0]         out_row,
  input wire logic [mme_pkg::IDX_W-1:0]         out_col,
  input wire logic signed [mme_pkg::SUM_W-1:0]  sum,
  input wire logic                              last
);
  import mme_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum) && $stable(out_row)
                                && $stable(out_col) && $stable(last))
    else $error("result item changed while stalled");

  // A load or an unused kind leaves the input channel open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != KIND_COMPUTE |=> in_ready)
    else $error("input blocked after a load item");

  // A compute item blocks the input channel
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_COMPUTE |=> !in_ready)
    else $error("input accepted right after a compute item");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .kind      (kind),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_row   (out_row),
  .out_col   (out_col),
  .sum       (sum),
  .last      (last)
);

`default_nettype wire

>>> tb/matrix_multiply_engine_core_tb.sv
// Self-checking testbench for matrix_multiply_engine_core: drives load and compute
// items and APB register writes, and predicts every C element in a scoreboard class.
// Depends on mme_pkg and the engine RTL.
`default_nettype none

module matrix_multiply_engine_core_tb;
  import mme_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE    = 2'd3;
  localparam int SLOTS          = MAX_DIM * MAX_DIM;
  localparam int ITEM_TARGET    = 260;
  localparam int QUIET_FROM     = 225;
  localparam int IDLE_GAP       = 16;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [SUM_W-1:0] s;
    logic                    l;
  } c_elem_t;

  class gemm_scoreboard;
    logic [DIM_W-1:0]         rows_reg;
    logic [DIM_W-1:0]         inner_reg;
    logic [DIM_W-1:0]         cols_reg;
    logic signed [ELEM_W-1:0] a_mat [SLOTS];
    logic signed [ELEM_W-1:0] b_mat [SLOTS];
    bit                       a_set [SLOTS];
    bit                       b_set [SLOTS];
    c_elem_t                  c_due [$];
    int                       errors;

    function new();
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      foreach (a_set[x]) begin
        a_set[x] = 1'b0;
        b_set[x] = 1'b0;
      end
      errors = 0;
    endfunction

    function int dim_used(logic [DIM_W-1:0] r);
      if (r == '0) return 1;
      if (r > DIM_W'(MAX_DIM)) return MAX_DIM;
      return int'(r);
    endfunction

    function int pending();
      return c_due.size();
    endfunction

    function void report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void note_config(logic [1:0] idx, logic [PDATA_W-1:0] data);
      case (idx)
        REG_ROWS_M:  rows_reg  = data[DIM_W-1:0];
        REG_INNER_K: inner_reg = data[DIM_W-1:0];
        REG_COLS_N:  cols_reg  = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] k_in, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic signed [ELEM_W-1:0] v);
      int      m;
      int      kk;
      int      n;
      int      slot;
      longint  acc;
      c_elem_t e;
      slot = int'(r) * MAX_DIM + int'(c);
      case (k_in)
        KIND_LOAD_A: begin
          a_mat[slot] = v;
          a_set[slot] = 1'b1;
        end
        KIND_LOAD_B: begin
          b_mat[slot] = v;
          b_set[slot] = 1'b1;
        end
        KIND_COMPUTE: begin
          m  = dim_used(rows_reg);
          kk = dim_used(inner_reg);
          n  = dim_used(cols_reg);
          for (int i = 0; i < m; i++) begin
            for (int j = 0; j < n; j++) begin
              acc = 0;
              for (int t = 0; t < kk; t++)
                acc += longint'(a_mat[i*MAX_DIM+t]) * longint'(b_mat[t*MAX_DIM+j]);
              if (acc > SUM_MAX) e.s = SUM_W'(SUM_MAX);
              else if (acc < SUM_MIN) e.s = SUM_W'(SUM_MIN);
              else e.s = SUM_W'(acc);
              e.r = IDX_W'(i);
              e.c = IDX_W'(j);
              e.l = (i == m - 1) && (j == n - 1);
              c_due = {c_due, e};
            end
          end
        end
        default: ;  // unused kind: drop
      endcase
    endfunction

    function void check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic signed [SUM_W-1:0] s, logic l);
      c_elem_t e;
      if (c_due.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d sum %0d", r, c, s));
        return;
      end
      e = c_due.pop_front();
      if (r !== e.r) report($sformatf("row got %0d want %0d", r, e.r));
      if (c !== e.c) report($sformatf("col got %0d want %0d (row %0d)", c, e.c, e.r));
      if (s !== e.s)
        report($sformatf("sum at (%0d,%0d) got %0d want %0d", e.r, e.c, s, e.s));
      if (l !== e.l) report($sformatf("last at (%0d,%0d) got %b want %b", e.r, e.c, l, e.l));
    endfunction

    function void final_check();
      if (c_due.size() != 0)
        report($sformatf("%0d results never arrived", c_due.size()));
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [PADDR_W-1:0]       paddr     = '0;
  logic [PDATA_W-1:0]       pwdata    = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [1:0]               kind      = '0;
  logic [IDX_W-1:0]         row       = '0;
  logic [IDX_W-1:0]         col       = '0;
  logic signed [ELEM_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  sum;
  logic                     last;

  gemm_scoreboard sb = new();
  int items_sent = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  matrix_multiply_engine_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .kind, .row, .col, .value,
    .out_valid, .out_ready, .out_row, .out_col, .sum, .last
  );

  always #5 clk = ~clk;

  function automatic logic [IDX_W-1:0] rand_idx(int hi);
    return IDX_W'($urandom_range(0, hi));
  endfunction

  // Lean on the extremes, otherwise anything goes.
  function automatic logic signed [ELEM_W-1:0] elem_value();
    case ($urandom_range(0, 6))
      0: return {1'b1, {(ELEM_W-1){1'b0}}};
      1: return {1'b0, {(ELEM_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic [1:0] k_in, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k_in;
    row      <= r;
    col      <= c;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k_in, r, c, v);
    if (k_in != KIND_UNUSED) items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic send_compute();
    send_item(KIND_COMPUTE, rand_idx(MAX_DIM-1), rand_idx(MAX_DIM-1), ELEM_W'($urandom()));
  endtask

  // Load every operand the next compute reads that has not been written yet.
  task automatic fill_operands();
    int m;
    int kk;
    int n;
    m  = sb.dim_used(sb.rows_reg);
    kk = sb.dim_used(sb.inner_reg);
    n  = sb.dim_used(sb.cols_reg);
    for (int i = 0; i < m; i++)
      for (int t = 0; t < kk; t++)
        if (!sb.a_set[i*MAX_DIM+t])
          send_item(KIND_LOAD_A, IDX_W'(i), IDX_W'(t), elem_value());
    for (int t = 0; t < kk; t++)
      for (int j = 0; j < n; j++)
        if (!sb.b_set[t*MAX_DIM+j])
          send_item(KIND_LOAD_B, IDX_W'(t), IDX_W'(j), elem_value());
  endtask

  // Drop valid, wait for every result, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int d);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[DIM_W-1:0] = DIM_W'(d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_config(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input int m, input int kk, input int n);
    settle();
    cfg_write(REG_ROWS_M, m);
    cfg_write(REG_INNER_K, kk);
    cfg_write(REG_COLS_N, n);
  endtask

  task automatic random_phase();
    int sel;
    int m;
    int kk;
    int n;
    int pick;
    int extremes [4];
    extremes = '{0, 1, 8, 15};
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      m  = extremes[$urandom_range(0, 3)];
      kk = extremes[$urandom_range(0, 3)];
      n  = extremes[$urandom_range(0, 3)];
    end else if (sel == 1) begin
      m  = $urandom_range(0, 15);
      kk = $urandom_range(0, 15);
      n  = $urandom_range(0, 15);
    end else begin
      m  = $urandom_range(1, 4);
      kk = $urandom_range(1, 4);
      n  = $urandom_range(1, 4);
    end
    set_dims(m, kk, n);
    if ($urandom_range(0, 7) == 0) cfg_write(REG_NONE, $urandom_range(0, 15));
    m  = sb.dim_used(sb.rows_reg);
    kk = sb.dim_used(sb.inner_reg);
    n  = sb.dim_used(sb.cols_reg);
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          send_item(KIND_UNUSED, rand_idx(MAX_DIM-1), rand_idx(MAX_DIM-1), elem_value());
        else if (pick == 1)
          send_item($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                    rand_idx(MAX_DIM-1), rand_idx(MAX_DIM-1), elem_value());
        else if (pick < 6)
          send_item(KIND_LOAD_A, rand_idx(m-1), rand_idx(kk-1), elem_value());
        else
          send_item(KIND_LOAD_B, rand_idx(kk-1), rand_idx(n-1), elem_value());
      end
      fill_operands();
      send_compute();
    end
  endtask

  // Result side: check each accepted result, then pick the next ready level.
  initial begin : result_sink
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_row, out_col, sum, last);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Single product of the most negative elements.
    set_dims(1, 1, 1);
    cfg_write(REG_NONE, 5);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, 16'sh8000);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, 16'sh8000);
    send_compute();

    // Zero rows acts as one; two maximal products overflow high.
    set_dims(0, 2, 1);
    send_item(KIND_LOAD_A, 3'd0, 3'd1, 16'sh8000);
    send_item(KIND_LOAD_B, 3'd1, 3'd0, 16'sh8000);
    send_compute();

    // Three large negative products overflow low; an unused kind is dropped.
    set_dims(1, 3, 1);
    send_item(KIND_LOAD_A, 3'd0, 3'd2, 16'sh8000);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
    send_item(KIND_LOAD_B, 3'd1, 3'd0, 16'sh7fff);
    send_item(KIND_LOAD_B, 3'd2, 3'd0, 16'sh7fff);
    send_item(KIND_UNUSED, 3'd7, 3'd7, 16'sh7fff);
    send_compute();

    // Rows above the maximum clamp to eight; touch the far corner of both stores.
    set_dims(15, 1, 1);
    send_item(KIND_LOAD_A, 3'd7, 3'd7, 16'sh0000);
    send_item(KIND_LOAD_B, 3'd7, 3'd7, -16'sh0001);
    fill_operands();
    send_compute();

    // Hold the receiver off through a full 8x8 result so the engine backs up.
    set_dims(8, 2, 8);
    fill_operands();
    hold_req = 1'b1;
    send_compute();
    repeat (4) send_item(KIND_LOAD_A, rand_idx(MAX_DIM-1), rand_idx(1), elem_value());
    settle();

    while (items_sent < ITEM_TARGET) random_phase();

    settle();
    sb.final_check();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
